@@ sv/bsc_pkg.sv @@
// ============================================================================
// bsc_pkg - shared types and constants for the button sequence challenge
// Item, result and configuration structs, action and event codes, reset values.
// ============================================================================
`default_nettype none

package bsc_pkg;

    // default sizing of the top level
    localparam int SEQ_MAX_DEF       = 8;
    localparam int BUTTON_COUNT_DEF  = 4;
    localparam int IDLE_BLINK_MS_DEF = 1000;

    // configuration register reset values
    localparam logic [31:0] TIMEOUT_MS_RST   = 32'd60000;
    localparam logic [3:0]  ATTEMPTS_MAX_RST = 4'd3;
    localparam logic [15:0] STEP_ON_MS_RST   = 16'd450;
    localparam logic [15:0] STEP_GAP_MS_RST  = 16'd200;

    // idle display patterns
    localparam logic [3:0] LED_IDLE_UNLOCKED = 4'h8;
    localparam logic [3:0] LED_IDLE_BLINK    = 4'h1;
    localparam logic [3:0] LED_OFF           = 4'h0;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_PRESS = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_PROGRESS = 3'd2,
        EV_APPROVED = 3'd3,
        EV_FAILED   = 3'd4,
        EV_TIMEOUT  = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_MS   = 2'd0,
        CFG_ATTEMPTS_MAX = 2'd1,
        CFG_STEP_ON_MS   = 2'd2,
        CFG_STEP_GAP_MS  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] timeout_ms;
        logic [3:0]  attempts_max;
        logic [15:0] step_on_ms;
        logic [15:0] step_gap_ms;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [2:0]  digit_index;
        logic [7:0]  random_byte;
        logic [3:0]  seq_length;
        logic [2:0]  button;
        logic [31:0] now_ms;
        logic        has_wallet;
        logic        unlocked;
    } t_item;

    typedef struct packed {
        logic [3:0]  leds;
        t_event      event_res;
        logic [31:0] req_id;
        logic [3:0]  position;
        logic [3:0]  attempts_left;
    } t_result;

endpackage

`default_nettype wire

@@ sv/bsc_blink.sv @@
// ============================================================================
// bsc_blink - idle blink phase
// Bit 0 of now_ms / BLINK_MS by an exact reciprocal multiply, split into two
// 16-bit halves whose products are registered before the final add.
// ============================================================================
`default_nettype none

module bsc_blink #(
    parameter int BLINK_MS = bsc_pkg::IDLE_BLINK_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_now,
    output logic        o_blink
);
    // round-up reciprocal, exact for every 32-bit dividend
    localparam int          LOG_D = $clog2(BLINK_MS);
    localparam int          SHIFT = 32 + LOG_D;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(BLINK_MS) - 64'd1)
                                    / 64'(BLINK_MS);
    localparam logic [32:0] RECIP_W = RECIP[32:0];

    logic [48:0] r_p_hi;
    logic [48:0] r_p_lo;
    logic [64:0] sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hi <= 49'(i_now[31:16]) * 49'(RECIP_W);
            r_p_lo <= 49'(i_now[15:0]) * 49'(RECIP_W);
        end
    end

    assign sum     = {r_p_hi, 16'd0} + 65'(r_p_lo);
    assign o_blink = sum[SHIFT];

endmodule

`default_nettype wire

@@ sv/bsc_core.sv @@
// ============================================================================
// bsc_core - challenge state and per-item update
// Holds the sequence store and challenge state; computes one result per
// committed item and updates the state at the same edge.
// ============================================================================
`default_nettype none

module bsc_core #(
    parameter int SEQ_MAX      = bsc_pkg::SEQ_MAX_DEF,
    parameter int BUTTON_COUNT = bsc_pkg::BUTTON_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_commit,
    input  bsc_pkg::t_item  i_item,
    input  logic            i_blink,
    input  bsc_pkg::t_cfg   i_cfg,
    output bsc_pkg::t_result o_result
);
    import bsc_pkg::*;

    localparam int SEQ_W = $clog2(BUTTON_COUNT);
    localparam int IDX_W = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;
    localparam int CNT_W = $clog2(SEQ_MAX + 1);

    // sequence store, no reset: entries are valid once loaded
    logic [SEQ_W-1:0] r_seq [SEQ_MAX];
    logic [SEQ_W-1:0] mod_tab [256];

    logic             r_active,  n_active;
    logic [31:0]      r_req_id,  n_req_id;
    logic [CNT_W-1:0] r_length,  n_length;
    logic [CNT_W-1:0] r_pos,     n_pos;
    logic [3:0]       r_att,     n_att;
    logic [31:0]      r_started, n_started;
    logic [31:0]      r_phase,   n_phase;
    logic [CNT_W-1:0] r_shown,   n_shown;
    logic             r_showing, n_showing;
    logic [3:0]       r_led,     n_led;

    logic [CNT_W-1:0] rd_cnt;
    logic [SEQ_W-1:0] rd_val;
    logic [CNT_W-1:0] slen;
    logic [3:0]       att_dec;
    logic [31:0]      elapsed;
    logic [16:0]      on_gap;
    logic [3:0]       step_led;
    logic [3:0]       prog_led;
    logic             seq_we;
    logic [CNT_W-1:0] rep_pos;
    logic [3:0]       rep_att;
    logic             finished;
    t_event           ev;

    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_tab[g] = SEQ_W'(g % BUTTON_COUNT);
    end

    // one read port: presses look at pos, ticks at the shown step
    assign rd_cnt = (i_item.action == ACT_PRESS) ? r_pos : r_shown;
    assign rd_val = r_seq[IDX_W'(rd_cnt)];

    assign elapsed = i_item.now_ms - r_phase;
    assign on_gap  = 17'(i_cfg.step_on_ms) + 17'(i_cfg.step_gap_ms);
    assign att_dec = (r_att != 4'd0) ? r_att - 4'd1 : 4'd0;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            step_led[i] = (32'(rd_val) == i);
            prog_led[i] = (32'(r_pos) > i);
        end
    end

    always_comb begin
        if (i_item.seq_length == 4'd0) begin
            slen = CNT_W'(1);
        end else if (32'(i_item.seq_length) > 32'(SEQ_MAX)) begin
            slen = CNT_W'(SEQ_MAX);
        end else begin
            slen = CNT_W'(i_item.seq_length);
        end
    end

    assign seq_we = i_commit && (i_item.action == ACT_LOAD) && !r_active &&
                    (32'(i_item.digit_index) < 32'(SEQ_MAX));

    always_comb begin
        n_active  = r_active;
        n_req_id  = r_req_id;
        n_length  = r_length;
        n_pos     = r_pos;
        n_att     = r_att;
        n_started = r_started;
        n_phase   = r_phase;
        n_shown   = r_shown;
        n_showing = r_showing;
        n_led     = r_led;
        ev        = EV_NONE;
        finished  = 1'b0;

        case (i_item.action)
            ACT_LOAD: begin
            end
            ACT_START: begin
                n_req_id  = r_req_id + 32'd1;
                n_active  = 1'b1;
                n_length  = slen;
                n_pos     = '0;
                n_att     = i_cfg.attempts_max;
                n_started = i_item.now_ms;
                n_phase   = i_item.now_ms;
                n_shown   = '0;
                n_showing = 1'b1;
                ev        = EV_STARTED;
            end
            ACT_PRESS: begin
                if (r_active && !r_showing &&
                    (32'(i_item.button) < 32'(BUTTON_COUNT))) begin
                    if (4'(i_item.button) == 4'(rd_val)) begin
                        n_pos = r_pos + CNT_W'(1);
                        if (n_pos >= r_length) begin
                            ev       = EV_APPROVED;
                            finished = 1'b1;
                        end else begin
                            ev = EV_PROGRESS;
                        end
                    end else begin
                        n_pos = '0;
                        n_att = att_dec;
                        if (att_dec == 4'd0) begin
                            ev       = EV_FAILED;
                            finished = 1'b1;
                        end else begin
                            ev        = EV_PROGRESS;
                            n_showing = 1'b1;
                            n_shown   = '0;
                            n_phase   = i_item.now_ms;
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (!r_active) begin
                    if (!i_item.has_wallet) begin
                        n_led = LED_OFF;
                    end else if (!i_item.unlocked) begin
                        n_led = i_blink ? LED_IDLE_BLINK : LED_OFF;
                    end else begin
                        n_led = LED_IDLE_UNLOCKED;
                    end
                end else if ((i_item.now_ms - r_started) > i_cfg.timeout_ms) begin
                    ev       = EV_TIMEOUT;
                    finished = 1'b1;
                end else if (r_showing) begin
                    if (r_shown >= r_length) begin
                        // trailing gap after the last step
                        if (elapsed >= 32'(i_cfg.step_gap_ms)) begin
                            n_showing = 1'b0;
                        end
                        n_led = LED_OFF;
                    end else if (elapsed < 32'(i_cfg.step_on_ms)) begin
                        n_led = step_led;
                    end else if (elapsed < 32'(on_gap)) begin
                        n_led = LED_OFF;
                    end else begin
                        n_shown = r_shown + CNT_W'(1);
                        n_phase = i_item.now_ms;
                    end
                end else begin
                    n_led = prog_led;
                end
            end
            default: begin
            end
        endcase

        rep_pos = n_pos;
        rep_att = n_att;

        if (finished) begin
            n_active  = 1'b0;
            n_length  = '0;
            n_pos     = '0;
            n_att     = 4'd0;
            n_started = 32'd0;
            n_phase   = 32'd0;
            n_shown   = '0;
            n_showing = 1'b0;
            n_led     = LED_OFF;
        end
    end

    always_comb begin
        o_result.leds          = n_led;
        o_result.event_res     = ev;
        o_result.req_id        = n_req_id;
        o_result.position      = 4'(rep_pos);
        o_result.attempts_left = rep_att;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_req_id  <= 32'd0;
            r_length  <= '0;
            r_pos     <= '0;
            r_att     <= 4'd0;
            r_started <= 32'd0;
            r_phase   <= 32'd0;
            r_shown   <= '0;
            r_showing <= 1'b0;
            r_led     <= LED_OFF;
        end else if (i_commit) begin
            r_active  <= n_active;
            r_req_id  <= n_req_id;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_att     <= n_att;
            r_started <= n_started;
            r_phase   <= n_phase;
            r_shown   <= n_shown;
            r_showing <= n_showing;
            r_led     <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq[IDX_W'(i_item.digit_index)] <= mod_tab[i_item.random_byte];
        end
    end

endmodule

`default_nettype wire

@@ sv/button_sequence_challenge.sv @@
// ============================================================================
// button_sequence_challenge - user-presence button sequence challenge engine
// Loads a random button sequence, plays it on LEDs, checks presses, times out.
// ============================================================================
// Takes one item per clock while the result is not stalled and returns one
// result per item through an input register, a register after the blink-period
// reciprocal products, and the result register. All challenge state updates in
// the cycle an item moves into the result register, so items may follow each
// other back to back. Input stall rises only when all three stages are full and
// the result is stalled. The sequence store has no reset; loads must cover every
// position a challenge uses. Configuration writes are always ready and take
// effect for items that arrive after the write.
`default_nettype none

module button_sequence_challenge #(
    parameter int SEQ_MAX       = bsc_pkg::SEQ_MAX_DEF,
    parameter int BUTTON_COUNT  = bsc_pkg::BUTTON_COUNT_DEF,
    parameter int IDLE_BLINK_MS = bsc_pkg::IDLE_BLINK_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_digit_index,
    input  logic [7:0]  i_random_byte,
    input  logic [3:0]  i_seq_length,
    input  logic [2:0]  i_button,
    input  logic [31:0] i_now_ms,
    input  logic        i_has_wallet,
    input  logic        i_unlocked,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_leds,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_req_id,
    output logic [3:0]  o_position,
    output logic [3:0]  o_attempts_left
);
    import bsc_pkg::*;

    t_cfg    r_cfg;
    logic    r_v1;
    logic    r_v2;
    t_item   r_s1;
    t_item   r_s2;
    logic    r_out_valid;
    t_result r_out;

    t_item   in_item;
    t_result result;
    logic    en_out;
    logic    en2;
    logic    en1;
    logic    in_fire;
    logic    commit;
    logic    blink;

    // each stage moves when the one after it is empty or moving
    assign en_out  = !r_out_valid || !i_out_stall;
    assign en2     = !r_v2 || en_out;
    assign en1     = !r_v1 || en2;
    assign in_fire = i_in_valid && en1;
    assign commit  = r_v2 && en_out;

    assign o_in_stall  = !en1;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item.action      = t_action'(i_action);
        in_item.digit_index = i_digit_index;
        in_item.random_byte = i_random_byte;
        in_item.seq_length  = i_seq_length;
        in_item.button      = i_button;
        in_item.now_ms      = i_now_ms;
        in_item.has_wallet  = i_has_wallet;
        in_item.unlocked    = i_unlocked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms   <= TIMEOUT_MS_RST;
            r_cfg.attempts_max <= ATTEMPTS_MAX_RST;
            r_cfg.step_on_ms   <= STEP_ON_MS_RST;
            r_cfg.step_gap_ms  <= STEP_GAP_MS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TIMEOUT_MS:   r_cfg.timeout_ms   <= i_cfg_data;
                CFG_ATTEMPTS_MAX: r_cfg.attempts_max <= i_cfg_data[3:0];
                CFG_STEP_ON_MS:   r_cfg.step_on_ms   <= i_cfg_data[15:0];
                CFG_STEP_GAP_MS:  r_cfg.step_gap_ms  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= in_item;
        end
        if (en2 && r_v1) begin
            r_s2 <= r_s1;
        end
        if (commit) begin
            r_out <= result;
        end
    end

    bsc_blink #(
        .BLINK_MS (IDLE_BLINK_MS)
    ) u_blink (
        .i_clk   (i_clk),
        .i_en    (en2 && r_v1),
        .i_now   (r_s1.now_ms),
        .o_blink (blink)
    );

    bsc_core #(
        .SEQ_MAX      (SEQ_MAX),
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_item   (r_s2),
        .i_blink  (blink),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_leds          = r_out.leds;
    assign o_event_res     = r_out.event_res;
    assign o_req_id        = r_out.req_id;
    assign o_position      = r_out.position;
    assign o_attempts_left = r_out.attempts_left;

endmodule

`default_nettype wire

@@ sv/bsc_checker.sv @@
// ============================================================================
// bsc_checker - port-level checks for button_sequence_challenge
// Result channel hold, request id sequencing and reported values on failure.
// ============================================================================
`default_nettype none

module bsc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  o_leds,
    input  logic [2:0]  o_event_res,
    input  logic [31:0] o_req_id,
    input  logic [3:0]  o_position,
    input  logic [3:0]  o_attempts_left
);
    import bsc_pkg::*;

    logic        out_xfer;
    logic [31:0] r_last_id;

    assign out_xfer = o_out_valid && !i_out_stall;

    // request id of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_id <= 32'd0;
        end else if (out_xfer) begin
            r_last_id <= o_req_id;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_leds) && $stable(o_event_res) &&
         $stable(o_req_id) && $stable(o_position) && $stable(o_attempts_left)))
        else $error("result changed while stalled");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_event_res == EV_STARTED) |-> (o_req_id == r_last_id + 32'd1))
        else $error("start did not advance request id by one");

    a_id_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_event_res != EV_STARTED) |-> (o_req_id == r_last_id))
        else $error("request id changed without a start");

    a_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_event_res == EV_FAILED) |->
        (o_position == 4'd0 && o_attempts_left == 4'd0 && o_leds == 4'd0))
        else $error("failed result with nonzero position, attempts or LEDs");

endmodule

bind button_sequence_challenge bsc_checker u_bsc_checker (.*);

`default_nettype wire

@@ tb/button_sequence_challenge_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// button_sequence_challenge_tb - self-checking bench for the challenge engine
// A directed table, then random challenges under several register settings.
// Results are checked against table values or an in-bench predictor. Both
// handshakes are paced with random stalls and gaps.
// ============================================================================

module button_sequence_challenge_tb;

    import bsc_pkg::*;

    localparam int          SEQ_MAX     = SEQ_MAX_DEF;
    localparam int          BUTTONS     = BUTTON_COUNT_DEF;
    localparam logic [31:0] BLINK_MS    = IDLE_BLINK_MS_DEF;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 500000;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_item       in_item = '0;
    logic        out_stall = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_leds;
    logic [2:0]  o_event_res;
    logic [31:0] o_req_id;
    logic [3:0]  o_position;
    logic [3:0]  o_attempts_left;

    // predictor copy of the registers and challenge state
    logic [31:0] c_timeout = TIMEOUT_MS_RST;
    logic [3:0]  c_att_max = ATTEMPTS_MAX_RST;
    logic [15:0] c_on = STEP_ON_MS_RST;
    logic [15:0] c_gap = STEP_GAP_MS_RST;

    bit          p_active = 1'b0;
    logic [31:0] p_next_id = '0;
    logic [1:0]  p_seq [SEQ_MAX];
    logic [3:0]  p_len = '0;
    logic [3:0]  p_pos = '0;
    logic [3:0]  p_att = '0;
    logic [31:0] p_t_start = '0;
    logic [31:0] p_t_phase = '0;
    logic [3:0]  p_shown = '0;
    bit          p_showing = 1'b0;
    logic [3:0]  p_leds = '0;

    t_result     pending_results [$];
    t_dir_row    dir_rows [$];
    int unsigned fail_count = 0;
    int unsigned live_items = 0;
    int unsigned cycle_count = 0;
    logic [31:0] clock_ms = '0;
    bit          tx_quiet = 1'b0;
    logic        final_part = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned rx_burst = 0;
    int unsigned rx_quiet = 0;

    button_sequence_challenge u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (in_item.action),
        .i_digit_index   (in_item.digit_index),
        .i_random_byte   (in_item.random_byte),
        .i_seq_length    (in_item.seq_length),
        .i_button        (in_item.button),
        .i_now_ms        (in_item.now_ms),
        .i_has_wallet    (in_item.has_wallet),
        .i_unlocked      (in_item.unlocked),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_leds          (o_leds),
        .o_event_res     (o_event_res),
        .o_req_id        (o_req_id),
        .o_position      (o_position),
        .o_attempts_left (o_attempts_left)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: one result per accepted item
    // ------------------------------------------------------------------------
    function automatic t_result challenge_step(input t_item it);
        t_result     r;
        logic [3:0]  len_in;
        logic [31:0] el;
        logic [3:0]  rep_pos;
        logic [3:0]  rep_att;
        bit          done;
        r = '0;
        done = 1'b0;
        r.event_res = EV_NONE;
        el = it.now_ms - p_t_phase;
        case (it.action)
            ACT_LOAD: begin
                if (!p_active) p_seq[it.digit_index] = it.random_byte[1:0];
            end
            ACT_START: begin
                len_in = it.seq_length;
                if (len_in == 0) len_in = 4'd1;
                if (len_in > SEQ_MAX) len_in = 4'(SEQ_MAX);
                p_next_id = p_next_id + 32'd1;
                p_active = 1'b1;
                p_len = len_in;
                p_pos = '0;
                p_att = c_att_max;
                p_t_start = it.now_ms;
                p_t_phase = it.now_ms;
                p_shown = '0;
                p_showing = 1'b1;
                r.event_res = EV_STARTED;
            end
            ACT_PRESS: begin
                if (p_active && it.button < BUTTONS && !p_showing) begin
                    if (it.button == {1'b0, p_seq[p_pos[2:0]]}) begin
                        p_pos = p_pos + 4'd1;
                        if (p_pos >= p_len) begin
                            r.event_res = EV_APPROVED;
                            done = 1'b1;
                        end else begin
                            r.event_res = EV_PROGRESS;
                        end
                    end else begin
                        p_pos = '0;
                        if (p_att != 0) p_att = p_att - 4'd1;
                        if (p_att == 0) begin
                            r.event_res = EV_FAILED;
                            done = 1'b1;
                        end else begin
                            // replay the sequence before the next attempt
                            r.event_res = EV_PROGRESS;
                            p_showing = 1'b1;
                            p_shown = '0;
                            p_t_phase = it.now_ms;
                        end
                    end
                end
            end
            default: begin
                if (!p_active) begin
                    if (!it.has_wallet) begin
                        p_leds = LED_OFF;
                    end else if (!it.unlocked) begin
                        p_leds = ((it.now_ms / BLINK_MS) % 2 == 1) ? LED_IDLE_BLINK : LED_OFF;
                    end else begin
                        p_leds = LED_IDLE_UNLOCKED;
                    end
                end else if (it.now_ms - p_t_start > c_timeout) begin
                    r.event_res = EV_TIMEOUT;
                    done = 1'b1;
                end else if (p_showing) begin
                    if (p_shown >= p_len) begin
                        if (el >= 32'(c_gap)) p_showing = 1'b0;
                        p_leds = LED_OFF;
                    end else if (el < 32'(c_on)) begin
                        p_leds = 4'(1 << p_seq[p_shown[2:0]]);
                    end else if (el < 32'(c_on) + 32'(c_gap)) begin
                        p_leds = LED_OFF;
                    end else begin
                        p_shown = p_shown + 4'd1;
                        p_t_phase = it.now_ms;
                    end
                end else begin
                    for (int i = 0; i < 4; i++) p_leds[i] = (i < p_pos);
                end
            end
        endcase
        rep_pos = p_pos;
        rep_att = p_att;
        if (done) begin
            p_active = 1'b0;
            p_len = '0;
            p_pos = '0;
            p_att = '0;
            p_t_start = '0;
            p_t_phase = '0;
            p_shown = '0;
            p_showing = 1'b0;
            p_leds = LED_OFF;
        end
        r.leds = p_leds;
        r.req_id = p_next_id;
        r.position = rep_pos;
        r.attempts_left = rep_att;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: leds %0h event %0d id %0d",
                       o_leds, o_event_res, o_req_id);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_leds !== want.leds) begin
                    $error("leds: expected %0h, got %0h", want.leds, o_leds);
                    fail_count++;
                end
                if (o_event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, o_event_res);
                    fail_count++;
                end
                if (o_req_id !== want.req_id) begin
                    $error("req_id: expected %0d, got %0d", want.req_id, o_req_id);
                    fail_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    fail_count++;
                end
                if (o_attempts_left !== want.attempts_left) begin
                    $error("attempts_left: expected %0d, got %0d",
                           want.attempts_left, o_attempts_left);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing: random stall bursts, quiet stretches, one long hold
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : rx_pace
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (rx_hold) begin
            out_stall <= 1'b1;
        end else if (rx_burst != 0) begin
            out_stall <= 1'b1;
            rx_burst <= rx_burst - 1;
        end else if (rx_quiet != 0 || final_part) begin
            out_stall <= 1'b0;
            if (rx_quiet != 0) rx_quiet <= rx_quiet - 1;
        end else begin
            out_stall <= (pick == 0);
            if (pick == 0) rx_burst <= $urandom_range(0, 15);
            if (pick == 1) rx_quiet <= $urandom_range(20, 120);
        end
    end

    // hold results back long enough that the pipeline fills and stalls input
    initial begin
        wait (live_items >= 100);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item mk_item(input t_action act, input logic [2:0] didx,
                                      input logic [7:0] rbyte, input logic [3:0] slen,
                                      input logic [2:0] btn, input logic [31:0] now,
                                      input logic wallet, input logic unl);
        t_item it;
        it.action = act;
        it.digit_index = didx;
        it.random_byte = rbyte;
        it.seq_length = slen;
        it.button = btn;
        it.now_ms = now;
        it.has_wallet = wallet;
        it.unlocked = unl;
        return it;
    endfunction

    function automatic t_result mk_result(input logic [3:0] leds, input t_event ev,
                                          input logic [31:0] id, input logic [3:0] pos,
                                          input logic [3:0] att);
        t_result r;
        r.leds = leds;
        r.event_res = ev;
        r.req_id = id;
        r.position = pos;
        r.attempts_left = att;
        return r;
    endfunction

    function automatic void add_row(input t_item it, input bit typed, input t_result want);
        t_dir_row row;
        row.it = it;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    // all fields but now_ms random; callers override what the action needs
    function automatic t_item rand_fields(input t_action act);
        t_item it;
        it.action = act;
        it.digit_index = 3'($urandom());
        it.random_byte = 8'($urandom());
        it.seq_length = 4'($urandom());
        it.button = 3'($urandom());
        it.now_ms = clock_ms;
        it.has_wallet = 1'($urandom());
        it.unlocked = 1'($urandom());
        return it;
    endfunction

    task automatic tx_gap();
        if (!tx_quiet && !final_part && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 16)) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result want;
        bit      was_active;
        @(negedge clk);
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        was_active = p_active;
        want = challenge_step(it);
        pending_results.push_back(typed ? typed_res : want);
        if (!((it.action == ACT_LOAD && was_active) ||
              (it.action == ACT_PRESS && want.event_res == EV_NONE)))
            live_items++;
        tx_gap();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_TIMEOUT_MS:   c_timeout = data;
            CFG_ATTEMPTS_MAX: c_att_max = data[3:0];
            CFG_STEP_ON_MS:   c_on = data[15:0];
            default:          c_gap = data[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits of the narrow registers carry junk
    task automatic set_config(input logic [31:0] tmo, input logic [3:0] att,
                              input logic [15:0] on_ms, input logic [15:0] gap_ms);
        drain();
        write_reg(CFG_TIMEOUT_MS, tmo);
        write_reg(CFG_ATTEMPTS_MAX, {28'($urandom()), att});
        write_reg(CFG_STEP_ON_MS, {16'($urandom()), on_ms});
        write_reg(CFG_STEP_GAP_MS, {16'($urandom()), gap_ms});
    endtask

    task automatic send_rand(input t_item it);
        send_item(it, 1'b0, '0);
    endtask

    // one challenge from load to finish, mostly well-formed presses
    task automatic one_challenge();
        t_item       it;
        int unsigned steps;
        int unsigned pick;
        int unsigned step_max;
        step_max = (32'(c_on) + 32'(c_gap)) / 2 + 1;
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 3) == 0) begin
                clock_ms = clock_ms + 32'($urandom_range(0, 3000));
                send_rand(rand_fields(ACT_TICK));
            end else begin
                send_rand(rand_fields(ACT_LOAD));
            end
        end
        it = rand_fields(ACT_START);
        it.seq_length = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
        send_rand(it);
        steps = 0;
        while (p_active && steps < 200) begin
            steps++;
            pick = $urandom_range(0, 31);
            if ((p_showing && pick != 0) || (!p_showing && pick < 3)) begin
                if ($urandom_range(0, 29) == 0)
                    clock_ms = p_t_start + c_timeout + 32'($urandom_range(0, 1));
                else
                    clock_ms = clock_ms + 32'($urandom_range(0, step_max));
                send_rand(rand_fields(ACT_TICK));
            end else begin
                clock_ms = clock_ms + 32'($urandom_range(0, 3));
                it = rand_fields(ACT_PRESS);
                if (p_showing) begin
                    it.button = 3'($urandom());
                end else if (pick < 6) begin
                    it.button = {1'b0, 2'(p_seq[p_pos[2:0]] + 2'($urandom_range(1, 3)))};
                end else if (pick == 6) begin
                    it.button = 3'($urandom_range(4, 7));
                end else if (pick == 7) begin
                    it = rand_fields(ACT_START);
                end else begin
                    it.button = {1'b0, p_seq[p_pos[2:0]]};
                end
                send_rand(it);
            end
        end
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned target;
        target = live_items + budget;
        while (live_items < target) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
            if ($urandom_range(0, 7) == 0)
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(4, 12)) begin
                    clock_ms = clock_ms + 32'($urandom_range(0, 5000));
                    send_rand(rand_fields(t_action'($urandom_range(0, 3))));
                end
            end else begin
                one_challenge();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle display, ignored press, loads, a one-step challenge, replace, timeout
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_result(4'h0, EV_NONE, 0, 0, 0));
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 1500, 1, 0), 1,
                mk_result(4'h1, EV_NONE, 0, 0, 0));
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 2000, 1, 0), 1,
                mk_result(4'h0, EV_NONE, 0, 0, 0));
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1), 1,
                mk_result(4'h8, EV_NONE, 0, 0, 0));
        add_row(mk_item(ACT_PRESS, 0, 0, 0, 0, 100, 0, 0), 1,
                mk_result(4'h8, EV_NONE, 0, 0, 0));
        add_row(mk_item(ACT_LOAD, 0, 8'h00, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 1, 8'hFF, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 2, 8'h55, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 3, 8'hAA, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 4, 8'h03, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 5, 8'h80, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 6, 8'h7F, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_LOAD, 7, 8'h01, 0, 0, 200, 0, 0), 0, '0);
        add_row(mk_item(ACT_START, 0, 0, 4'd0, 0, 10000, 0, 0), 1,
                mk_result(4'h8, EV_STARTED, 1, 0, 3));
        add_row(mk_item(ACT_LOAD, 0, 8'h02, 0, 0, 10000, 0, 0), 0, '0);
        add_row(mk_item(ACT_PRESS, 0, 0, 0, 0, 10000, 0, 0), 0, '0);
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 10000, 0, 0), 0, '0);
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 10450, 0, 0), 0, '0);
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 10650, 0, 0), 0, '0);
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 10850, 0, 0), 0, '0);
        add_row(mk_item(ACT_PRESS, 0, 0, 0, 3'd4, 10880, 0, 0), 0, '0);
        add_row(mk_item(ACT_PRESS, 0, 0, 0, 3'd0, 10900, 0, 0), 1,
                mk_result(4'h0, EV_APPROVED, 1, 1, 3));
        add_row(mk_item(ACT_START, 0, 0, 4'd15, 0, 20000, 0, 0), 0, '0);
        add_row(mk_item(ACT_START, 0, 0, 4'd2, 0, 20000, 0, 0), 1,
                mk_result(4'h0, EV_STARTED, 3, 0, 3));
        add_row(mk_item(ACT_TICK, 0, 0, 0, 0, 80001, 1, 1), 1,
                mk_result(4'h0, EV_TIMEOUT, 3, 0, 3));

        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        clock_ms = 32'd100000;
        run_phase(200);
        set_config(32'd1, 4'd1, 16'd1, 16'd0);
        run_phase(150);
        set_config(32'hFFFF_FFFF, 4'd15, 16'hFFFF, 16'hFFFF);
        run_phase(200);
        // zero attempts: first wrong press fails
        set_config(32'd5000, 4'd0, 16'd20, 16'd10);
        run_phase(200);
        set_config(32'($urandom_range(2000, 40000)), 4'($urandom_range(1, 15)),
                   16'($urandom_range(1, 300)), 16'($urandom_range(0, 300)));
        run_phase(200);
        set_config(TIMEOUT_MS_RST, ATTEMPTS_MAX_RST, STEP_ON_MS_RST, STEP_GAP_MS_RST);
        final_part <= 1'b1;
        run_phase(250);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
